@@ sv/ldsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ldsd_pkg: shared types and constants of the laser dock stall detector
// Request and status codes, register indexes, field widths, cell control.
// ----------------------------------------------------------------------------
package ldsd_pkg;

    localparam int DIST_W     = 16;   // raw sensor distance
    localparam int FILT_W     = 24;   // Q16.8 filtered distance
    localparam int TIME_W     = 32;   // millisecond timestamps
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ALPHA_W    = 17;   // Q16 alpha, 0..65536
    localparam int ALPHA_X_RANGE = 8; // dt/tau span covered by the alpha table

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_POLL   = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_DOCK_THR   = 3'd1,
        ST_DOCK_STALL = 3'd2,
        ST_TIMEOUT    = 3'd3,
        ST_WAITING    = 3'd4
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_DUR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BELOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MED_LEN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_TAU    = 3'd7;

    // Control shared by every median cell.
    typedef struct packed {
        logic ins;   // shift the window one place, newest into cell 0
        logic load;  // copy held sample into the rotating slot, clear rank
        logic rot;   // rank against the slot, pass the slot to the neighbor
    } t_cell_ctl;

endpackage

@@ sv/ldsd_if.sv @@
// ----------------------------------------------------------------------------
// ldsd_if: request and result channels
// Valid/ready channels; a word moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ldsd_req_if import ldsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [DIST_W-1:0] raw_distance;
    logic              sample_ok;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, req_type, raw_distance, sample_ok, time_ms,
                    input ready);
    modport sink   (input valid, req_type, raw_distance, sample_ok, time_ms,
                    output ready);
endinterface

interface ldsd_res_if import ldsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FILT_W-1:0] filtered_distance;
    logic [2:0]        status;
    logic              stop_drive;

    modport source (output valid, filtered_distance, status, stop_drive,
                    input ready);
    modport sink   (input valid, filtered_distance, status, stop_drive,
                    output ready);
endinterface

@@ sv/ldsd_cell.sv @@
// ----------------------------------------------------------------------------
// ldsd_cell: one median window cell
// Holds one sample and ranks it against the samples rotating past.
// ----------------------------------------------------------------------------
module ldsd_cell import ldsd_pkg::*; #(
    parameter int IW     = 3,
    parameter int CW     = 4,
    parameter int MY_IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_act,
    input  logic [DIST_W-1:0] i_w,
    input  logic [DIST_W-1:0] i_pv,
    input  logic [IW-1:0]     i_pi,
    input  logic              i_pe,
    output logic [DIST_W-1:0] o_w,
    output logic [DIST_W-1:0] o_pv,
    output logic [IW-1:0]     o_pi,
    output logic              o_pe,
    output logic [CW-1:0]     o_cnt
);
    logic [DIST_W-1:0] r_w;
    logic [DIST_W-1:0] r_pv;
    logic [IW-1:0]     r_pi;
    logic              r_pe;
    logic [CW-1:0]     r_cnt;
    logic              w_less;

    // Ties break on the origin index so every rank is distinct.
    assign w_less = r_pe && ((r_pv < r_w) || ((r_pv == r_w) && (r_pi < IW'(MY_IDX))));

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_w <= i_w;
        end
        if (i_ctl.load) begin
            r_pv  <= r_w;
            r_pi  <= IW'(MY_IDX);
            r_pe  <= i_act;
            r_cnt <= '0;
        end else if (i_ctl.rot) begin
            r_pv <= i_pv;
            r_pi <= i_pi;
            r_pe <= i_pe;
            if (w_less) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_w   = r_w;
    assign o_pv  = r_pv;
    assign o_pi  = r_pi;
    assign o_pe  = r_pe;
    assign o_cnt = r_cnt;
endmodule

@@ sv/ldsd_div.sv @@
// ----------------------------------------------------------------------------
// ldsd_div: alpha table index divider
// Rounded dt*DEPTH/(8*tau), one quotient bit per cycle, saturation flag.
// ----------------------------------------------------------------------------
module ldsd_div import ldsd_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [TIME_W-1:0]        i_dt,
    input  logic [15:0]              i_tau,
    output logic                     o_done,
    output logic                     o_sat,
    output logic [$clog2(DEPTH)-1:0] o_q
);
    localparam int QB = $clog2(DEPTH);
    localparam int NW = TIME_W + QB + 1;
    localparam int KW = $clog2(QB + 1);

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_DONE} t_dstate;

    t_dstate        r_state;
    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_lim;
    logic [NW-1:0]  r_den;
    logic [QB-1:0]  r_q;
    logic [KW-1:0]  r_k;
    logic           r_sat;
    logic           w_ge;

    assign w_ge = (r_num >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE, D_DONE: begin
                    if (i_start) begin
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    r_state <= (r_num >= r_lim) ? D_DONE : D_RUN;
                end
                D_RUN: begin
                    if (r_k == KW'(1)) begin
                        r_state <= D_DONE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
        if (i_start) begin
            r_num <= NW'(i_dt) * NW'(DEPTH) + NW'({i_tau, 2'b00});
            r_lim <= NW'({i_tau, 3'b000}) * NW'(DEPTH);
            r_den <= NW'({i_tau, 3'b000}) << (QB - 1);
            r_q   <= '0;
            r_k   <= KW'(QB);
            r_sat <= 1'b0;
        end else if (r_state == D_CHK) begin
            r_sat <= (r_num >= r_lim);
        end else if (r_state == D_RUN) begin
            // restore step: take one quotient bit, move the divisor down
            if (w_ge) begin
                r_num <= r_num - r_den;
            end
            r_q   <= {r_q[QB-2:0], w_ge};
            r_den <= r_den >> 1;
            r_k   <= r_k - 1'b1;
        end
    end

    assign o_done = (r_state == D_DONE);
    assign o_sat  = r_sat;
    assign o_q    = r_q;
endmodule

@@ sv/ldsd_alpha_rom.sv @@
// ----------------------------------------------------------------------------
// ldsd_alpha_rom: EMA alpha table
// alpha = 1 - exp(-x) in Q16, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module ldsd_alpha_rom import ldsd_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output logic [ALPHA_W-1:0]       o_alpha
);
    // exp(-step) as a Taylor sum through the 24th-order term in Q32
    function automatic logic [63:0] exp_step(input logic [63:0] y);
        logic [63:0] term;
        longint      sum;
        term = 64'h1_0000_0000;
        sum  = longint'(term);
        for (int k = 1; k <= 24; k++) begin
            term = ((term * y) >> 32) / 64'(k);
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    function automatic logic [ALPHA_W-1:0] alpha_at(input logic [63:0] step, input int idx);
        logic [63:0] e;
        logic [63:0] v;
        e = 64'h1_0000_0000;
        for (int i = 0; i < idx; i++) begin
            e = (e * step + 64'h8000_0000) >> 32;
        end
        v = (64'h1_0000_0000 - e + 64'd32768) >> 16;
        return v[ALPHA_W-1:0];
    endfunction

    localparam logic [63:0] Y    = (64'(ALPHA_X_RANGE) << 32) / 64'(DEPTH);
    localparam logic [63:0] STEP = exp_step(Y);

    logic [ALPHA_W-1:0] w_tab [DEPTH];
    logic [ALPHA_W-1:0] r_alpha;

    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        localparam logic [ALPHA_W-1:0] V = alpha_at(STEP, g);
        assign w_tab[g] = V;
    end

    always_ff @(posedge i_clk) begin
        r_alpha <= w_tab[i_addr];
    end

    assign o_alpha = r_alpha;
endmodule

@@ sv/laser_dock_stall_detector.sv @@
// ----------------------------------------------------------------------------
// laser_dock_stall_detector: docking monitor on a laser distance stream
// Median window as a ring of ranking cells, EMA with table alpha, dock/stall.
// ----------------------------------------------------------------------------
// Sequence: start and poll words go straight to the report state; an
//   unfiltered sample passes the update state first; a filtered sample is
//   shifted in, the ring loaded and rotated and the median picked, and when
//   the EMA multiplies it also waits for the alpha divider started at the shift.
// Throughput: one word at a time; the next is taken only back in idle.
// Reset (synchronous, active low): configuration registers take their defaults,
//   filter and stall state clear, no output word pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module laser_dock_stall_detector import ldsd_pkg::*; #(
    parameter int MEDIAN_MAX      = 8,
    parameter int MIN_INTERVAL_MS = 100,
    parameter int ALPHA_ROM_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ldsd_req_if.sink              i_req,
    ldsd_res_if.source            o_res
);
    localparam int FW = $clog2(MEDIAN_MAX + 1);          // fill / rank width
    localparam int IW = (MEDIAN_MAX > 1) ? $clog2(MEDIAN_MAX) : 1;
    localparam int QB = $clog2(ALPHA_ROM_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_LOAD, S_ROT, S_PICK, S_WDIV, S_ROM,
        S_MUL1, S_MUL2, S_SUM, S_UPD, S_REP
    } t_state;

    typedef enum logic [1:0] {EM_INIT, EM_HOLD, EM_FULL} t_ema_mode;

    // ---------------- registers ----------------
    t_state             r_state;
    t_ema_mode          r_mode;
    logic [FW-1:0]      r_rot;

    // configuration
    logic [15:0]        r_stall_thr;
    logic [15:0]        r_stall_dur;
    logic [TIME_W-1:0]  r_timeout;
    logic [15:0]        r_stall_max;
    logic [15:0]        r_stop_below;
    logic               r_filter_on;
    logic [3:0]         r_med_len;
    logic [15:0]        r_tau;

    // filter and dock state
    logic [FW-1:0]      r_fill;
    logic [FILT_W-1:0]  r_ema;
    logic               r_ema_ready;
    logic [TIME_W-1:0]  r_ftime;
    logic [FILT_W-1:0]  r_prev;
    logic               r_prev_ok;
    logic [TIME_W-1:0]  r_ptime;
    logic               r_have;
    logic               r_stalling;
    logic [TIME_W-1:0]  r_stall_start;
    logic               r_docked;
    logic [TIME_W-1:0]  r_start_time;

    // current word
    logic [DIST_W-1:0]  r_raw;
    logic               r_ok;
    logic [TIME_W-1:0]  r_t;
    logic [FILT_W-1:0]  r_f;
    logic [FILT_W-1:0]  r_med;
    logic [FILT_W-1:0]  r_shown;
    logic [ALPHA_W-1:0] r_alpha;
    logic [FILT_W+ALPHA_W-1:0] r_p1;
    logic [FILT_W+ALPHA_W-1:0] r_p2;

    // output word
    logic               r_o_valid;
    logic [FILT_W-1:0]  r_o_dist;
    logic [2:0]         r_o_status;
    logic               r_o_stop;

    // ---------------- median ring ----------------
    t_cell_ctl          w_cell_ctl;
    logic [DIST_W-1:0]  w_w   [MEDIAN_MAX];
    logic [DIST_W-1:0]  w_pv  [MEDIAN_MAX];
    logic [IW-1:0]      w_pi  [MEDIAN_MAX];
    logic               w_pe  [MEDIAN_MAX];
    logic [FW-1:0]      w_cnt [MEDIAN_MAX];
    logic               w_act [MEDIAN_MAX];

    assign w_cell_ctl.ins  = (r_state == S_INS);
    assign w_cell_ctl.load = (r_state == S_LOAD);
    assign w_cell_ctl.rot  = (r_state == S_ROT);

    for (genvar g = 0; g < MEDIAN_MAX; g++) begin : g_cell
        logic [DIST_W-1:0] w_in;
        if (g == 0) begin : g_head
            assign w_in = r_raw;
        end else begin : g_body
            assign w_in = w_w[g-1];
        end
        // cells 0..fill-1 hold the newest samples, newest in cell 0
        assign w_act[g] = (FW'(g) < r_fill);

        ldsd_cell #(
            .IW     (IW),
            .CW     (FW),
            .MY_IDX (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_ctl (w_cell_ctl),
            .i_act (w_act[g]),
            .i_w   (w_in),
            .i_pv  (w_pv[(g + MEDIAN_MAX - 1) % MEDIAN_MAX]),
            .i_pi  (w_pi[(g + MEDIAN_MAX - 1) % MEDIAN_MAX]),
            .i_pe  (w_pe[(g + MEDIAN_MAX - 1) % MEDIAN_MAX]),
            .o_w   (w_w[g]),
            .o_pv  (w_pv[g]),
            .o_pi  (w_pi[g]),
            .o_pe  (w_pe[g]),
            .o_cnt (w_cnt[g])
        );
    end

    // effective window length: zero acts as one, clamp at MEDIAN_MAX
    logic [4:0]    w_len5;
    logic [FW:0]   w_len;
    logic [FW:0]   w_fill_inc;
    logic [FW-1:0] w_fill_new;

    assign w_len5 = {1'b0, r_med_len};
    always_comb begin
        if (r_med_len == 4'd0) begin
            w_len = (FW+1)'(1);
        end else if (w_len5 > 5'(MEDIAN_MAX)) begin
            w_len = (FW+1)'(MEDIAN_MAX);
        end else begin
            w_len = (FW+1)'(r_med_len);
        end
        w_fill_inc = {1'b0, r_fill} + 1'b1;
        w_fill_new = (w_fill_inc < w_len) ? w_fill_inc[FW-1:0] : w_len[FW-1:0];
    end

    // pick the middle rank(s) out of the ring
    logic [FW-1:0]     w_k_hi;
    logic [FW-1:0]     w_k_lo;
    logic [DIST_W-1:0] w_v_hi;
    logic [DIST_W-1:0] w_v_lo;
    logic [DIST_W:0]   w_pair;
    logic [FILT_W-1:0] w_med;

    assign w_k_hi = r_fill >> 1;
    assign w_k_lo = w_k_hi - 1'b1;
    always_comb begin
        w_v_hi = '0;
        w_v_lo = '0;
        for (int i = 0; i < MEDIAN_MAX; i++) begin
            if (w_act[i] && (w_cnt[i] == w_k_hi)) w_v_hi = w_v_hi | w_w[i];
            if (w_act[i] && (w_cnt[i] == w_k_lo)) w_v_lo = w_v_lo | w_w[i];
        end
        w_pair = {1'b0, w_v_lo} + {1'b0, w_v_hi};
        w_med  = r_fill[0] ? {w_v_hi, 8'h00} : {w_pair, 7'b0};
    end

    // ---------------- alpha divider and table ----------------
    logic [TIME_W-1:0]  w_dt;
    logic               w_div_start;
    logic               w_div_done;
    logic               w_div_sat;
    logic [QB-1:0]      w_div_q;
    logic [ALPHA_W-1:0] w_rom_alpha;

    assign w_dt        = r_t - r_ftime;
    assign w_div_start = (r_state == S_INS) && (r_tau != 16'd0) && r_ema_ready
                         && (w_dt != '0);

    ldsd_div #(
        .DEPTH (ALPHA_ROM_DEPTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dt    (w_dt),
        .i_tau   (r_tau),
        .o_done  (w_div_done),
        .o_sat   (w_div_sat),
        .o_q     (w_div_q)
    );

    ldsd_alpha_rom #(
        .DEPTH (ALPHA_ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_addr  (w_div_q),
        .o_alpha (w_rom_alpha)
    );

    logic [FILT_W+ALPHA_W:0] w_ema_sum;
    assign w_ema_sum = {1'b0, r_p1} + {1'b0, r_p2} + (FILT_W+ALPHA_W+1)'(32768);

    // ---------------- dock and stall tests ----------------
    logic [FILT_W-1:0] w_diff;
    logic              w_dock;
    logic              w_gap;
    logic              w_near;
    logic              w_stall_hit;

    always_comb begin
        w_diff      = (r_f > r_prev) ? (r_f - r_prev) : (r_prev - r_f);
        w_dock      = (r_stop_below != 16'd0) && r_ok && (r_f < {r_stop_below, 8'h00});
        w_gap       = ((r_t - r_ptime) >= TIME_W'(MIN_INTERVAL_MS));
        w_near      = (r_stall_max == 16'd0) || (r_ok && (r_f < {r_stall_max, 8'h00}));
        w_stall_hit = r_ok && r_prev_ok && (w_diff < {r_stall_thr, 8'h00}) && w_near;
    end

    // status as seen at the word's time
    t_status w_status;
    always_comb begin
        if ((r_t - r_start_time) > r_timeout) begin
            w_status = ST_TIMEOUT;
        end else if (!r_have) begin
            w_status = ST_WAITING;
        end else if (r_docked) begin
            w_status = ST_DOCK_THR;
        end else if (r_stalling && ((r_t - r_stall_start) >= TIME_W'(r_stall_dur))) begin
            w_status = ST_DOCK_STALL;
        end else begin
            w_status = ST_RUNNING;
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_o_valid     <= 1'b0;
            r_stall_thr   <= 16'd5;
            r_stall_dur   <= 16'd500;
            r_timeout     <= 32'd10000;
            r_stall_max   <= 16'd0;
            r_stop_below  <= 16'd0;
            r_filter_on   <= 1'b1;
            r_med_len     <= 4'd5;
            r_tau         <= 16'd100;
            r_fill        <= '0;
            r_ema         <= '0;
            r_ema_ready   <= 1'b0;
            r_ftime       <= '0;
            r_prev        <= '0;
            r_prev_ok     <= 1'b0;
            r_ptime       <= '0;
            r_have        <= 1'b0;
            r_stalling    <= 1'b0;
            r_stall_start <= '0;
            r_docked      <= 1'b0;
            r_start_time  <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STALL_THR:  r_stall_thr  <= i_cfg_data[15:0];
                    CFG_STALL_DUR:  r_stall_dur  <= i_cfg_data[15:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                    CFG_STALL_MAX:  r_stall_max  <= i_cfg_data[15:0];
                    CFG_STOP_BELOW: r_stop_below <= i_cfg_data[15:0];
                    CFG_FILTER_ON:  r_filter_on  <= i_cfg_data[0];
                    CFG_MED_LEN:    r_med_len    <= i_cfg_data[3:0];
                    CFG_EMA_TAU:    r_tau        <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // drop the output word once taken, unless a new one replaces it
            if (r_o_valid && o_res.ready && (r_state != S_REP)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_raw   <= i_req.raw_distance;
                        r_ok    <= i_req.sample_ok;
                        r_t     <= i_req.time_ms;
                        // a start reports zero, others the stored distance
                        r_shown <= (r_prev_ok && (t_req'(i_req.req_type) != REQ_START)) ?
                                   r_prev : '0;
                        unique case (t_req'(i_req.req_type))
                            REQ_START: begin
                                // clear the run and restart the clock
                                r_fill       <= '0;
                                r_ema        <= '0;
                                r_ema_ready  <= 1'b0;
                                r_ftime      <= i_req.time_ms;
                                r_prev       <= '0;
                                r_prev_ok    <= 1'b0;
                                r_ptime      <= i_req.time_ms;
                                r_have       <= 1'b0;
                                r_stalling   <= 1'b0;
                                r_docked     <= 1'b0;
                                r_start_time <= i_req.time_ms;
                                r_state      <= S_REP;
                            end
                            REQ_SAMPLE: begin
                                if (i_req.sample_ok && r_filter_on) begin
                                    r_state <= S_INS;
                                end else begin
                                    r_f     <= i_req.sample_ok ?
                                               {i_req.raw_distance, 8'h00} : '0;
                                    r_state <= S_UPD;
                                end
                            end
                            REQ_POLL, REQ_RSVD: begin
                                r_state <= S_REP;
                            end
                            default: r_state <= S_REP;
                        endcase
                    end
                end
                S_INS: begin
                    // window shifts in the cells; pick the EMA path
                    r_fill  <= w_fill_new;
                    r_ftime <= r_t;
                    if ((r_tau == 16'd0) || !r_ema_ready) begin
                        r_mode <= EM_INIT;
                    end else if (w_dt == '0) begin
                        r_mode <= EM_HOLD;
                    end else begin
                        r_mode <= EM_FULL;
                    end
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_rot   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_rot == FW'(MEDIAN_MAX - 1)) begin
                        r_state <= S_PICK;
                    end else begin
                        r_rot <= r_rot + 1'b1;
                    end
                end
                S_PICK: begin
                    r_med <= w_med;
                    unique case (r_mode)
                        EM_INIT: begin
                            r_ema       <= w_med;
                            r_ema_ready <= 1'b1;
                            r_f         <= w_med;
                            r_state     <= S_UPD;
                        end
                        EM_HOLD: begin
                            r_f     <= r_ema;
                            r_state <= S_UPD;
                        end
                        default: r_state <= S_WDIV;
                    endcase
                end
                S_WDIV: begin
                    if (w_div_done) begin
                        r_state <= S_ROM;
                    end
                end
                S_ROM: begin
                    r_alpha <= w_div_sat ? ALPHA_W'(65536) : w_rom_alpha;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1    <= (ALPHA_W'(65536) - r_alpha) * r_ema;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= r_alpha * r_med;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_ema   <= w_ema_sum[16 +: FILT_W];
                    r_f     <= w_ema_sum[16 +: FILT_W];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_shown <= r_ok ? r_f : '0;
                    if (w_dock) begin
                        r_docked <= 1'b1;
                    end
                    if (!r_have) begin
                        // first sample since start: store only
                        r_prev    <= r_f;
                        r_prev_ok <= r_ok;
                        r_ptime   <= r_t;
                        r_have    <= 1'b1;
                    end else if (w_gap) begin
                        r_prev    <= r_f;
                        r_prev_ok <= r_ok;
                        r_ptime   <= r_t;
                        if (w_stall_hit) begin
                            if (!r_stalling) begin
                                r_stalling    <= 1'b1;
                                r_stall_start <= r_t;
                            end
                        end else begin
                            r_stalling <= 1'b0;
                        end
                    end
                    r_state <= S_REP;
                end
                S_REP: begin
                    // hold until the output register is free
                    if (!r_o_valid || o_res.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_dist   <= r_shown;
                        r_o_status <= w_status;
                        r_o_stop   <= (w_status == ST_DOCK_THR) ||
                                      (w_status == ST_DOCK_STALL) ||
                                      (w_status == ST_TIMEOUT);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready             = (r_state == S_IDLE);
    assign o_res.valid             = r_o_valid;
    assign o_res.filtered_distance = r_o_dist;
    assign o_res.status            = r_o_status;
    assign o_res.stop_drive        = r_o_stop;

    // ---------------- assertions ----------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("word accepted while another is in flight");

    a_stop_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.stop_drive == ((o_res.status == ST_DOCK_THR) ||
                                              (o_res.status == ST_DOCK_STALL) ||
                                              (o_res.status == ST_TIMEOUT))))
        else $error("stop_drive disagrees with status");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MEDIAN_MAX))
        else $error("window fill beyond ring length");

    a_alpha_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROM) |-> w_div_done)
        else $error("alpha read before divider finished");
endmodule
